FILE: rtl/quaternion_torque_step_defines.svh
// Assertion macros shared by the checker of the quaternion torque step block.
// No dependencies; the using scope must provide clk and rst_n.
`ifndef QUATERNION_TORQUE_STEP_DEFINES_SVH
`define QUATERNION_TORQUE_STEP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define QTS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qts: same-cycle property failed");

// Next-cycle implication, off while reset is asserted.
`define QTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qts: next-cycle property failed");

// Next-cycle implication that also holds across reset.
`define QTS_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qts: reset property failed");

`endif

FILE: rtl/qts_pkg.sv
// Shared widths, types and saturation helpers of the quaternion torque step block.
// No dependencies.
package qts_pkg;

  localparam int CW     = 16;             // component width
  localparam int FB     = 14;             // fraction bits
  localparam int REG_W  = 16;             // configuration register width
  localparam int KSH    = 8;              // rate factor shift
  localparam int INCSH  = 16;             // increment shift
  localparam int MQ_W   = 2 * CW - FB;    // one quaternion product
  localparam int E_W    = MQ_W + 2;       // error sums
  localparam int ES_W   = CW + 1;         // saturated and sign-flipped error
  localparam int DP_W   = ES_W + CW - FB; // derivative product
  localparam int DS_W   = DP_W + 2;       // derivative sums
  localparam int DV_W   = CW + 2;         // saturated derivative
  localparam int K_W    = 2 * REG_W - KSH;
  localparam int PR_W   = DV_W + K_W + 1;
  localparam int INC_W  = PR_W - INCSH;
  localparam int NQ_W   = INC_W + 1;
  // With these widths every magnitude stays below 2^30, so no pre-shift is needed.
  localparam int MAG_W  = NQ_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int RT_W   = SUM_W / 2;      // root bits, one per root stage
  localparam int NUM_W  = MAG_W + FB + 1; // dividend
  localparam int QB     = FB + 1;         // quotient bits, one per divide stage
  localparam int CFG_IDX_W = 1;
  localparam int UNIT   = 1 << FB;
  localparam longint O_HI = (longint'(1) << (CW - 1)) - 1;
  localparam longint O_LO = -O_HI - 1;

  localparam logic [REG_W-1:0] STEP_RST = REG_W'(656);
  localparam logic [REG_W-1:0] GAIN_RST = REG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP = 1'b0,
    REG_GAIN = 1'b1
  } cfg_reg_t;

  typedef logic [3:0][CW-1:0]    quat_t;
  typedef logic [3:0][MAG_W-1:0] mag4_t;
  typedef logic [3:0][QB-1:0]    quo4_t;

  typedef struct packed {
    logic valid;
    logic last;
  } side_t;

  function automatic logic signed [CW-1:0] sat_e(input logic signed [E_W-1:0] v);
    logic same;
    same = (&v[E_W-1:CW-1]) | ~(|v[E_W-1:CW-1]);
    if (same) return v[CW-1:0];
    else if (v[E_W-1]) return {1'b1, {(CW-1){1'b0}}};
    else return {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic logic signed [DV_W-1:0] sat_d(input logic signed [DS_W-1:0] v);
    logic same;
    same = (&v[DS_W-1:DV_W-1]) | ~(|v[DS_W-1:DV_W-1]);
    if (same) return v[DV_W-1:0];
    else if (v[DS_W-1]) return {1'b1, {(DV_W-1){1'b0}}};
    else return {1'b0, {(DV_W-1){1'b1}}};
  endfunction

  function automatic logic signed [CW-1:0] sat_o(input logic signed [QB+1:0] v);
    longint x;
    x = 64'(v);
    if (x > O_HI) return CW'(O_HI);
    else if (x < O_LO) return CW'(O_LO);
    else return CW'(x);
  endfunction

endpackage

FILE: rtl/qts_front.sv
// Front pipeline: attitude error, derivative, increment, magnitudes and sum of squares.
// Eight register stages. Depends on qts_pkg.
module qts_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  qts_pkg::side_t             in_side,
  input  qts_pkg::quat_t             q_in,
  input  qts_pkg::quat_t             g_in,
  input  logic [qts_pkg::K_W-1:0]    k,
  output qts_pkg::side_t             out_side,
  output qts_pkg::mag4_t             mag,
  output logic [3:0]                 neg,
  output logic [qts_pkg::SUM_W-1:0]  sum
);
  import qts_pkg::*;

  side_t                   sd_r [1:8];
  quat_t                   qp_r [1:5];
  logic signed [MQ_W-1:0]  mq_r [4][4];
  logic signed [MQ_W-1:0]  mq_nxt [4][4];
  logic signed [ES_W-1:0]  ev_r [1:3];
  logic signed [ES_W-1:0]  ev_nxt [1:3];
  logic signed [DP_W-1:0]  dp_r [1:3][4];
  logic signed [DP_W-1:0]  dp_nxt [1:3][4];
  logic signed [DV_W-1:0]  dv_r [4];
  logic signed [DV_W-1:0]  dv_nxt [4];
  logic signed [PR_W-1:0]  pr_r [4];
  logic signed [PR_W-1:0]  pr_nxt [4];
  mag4_t                   mag6_r, mag6_nxt, mag7_r, mag8_r;
  logic [3:0]              neg6_r, neg6_nxt, neg7_r, neg8_r;
  logic [SQ_W-1:0]         sq_r [4];
  logic [SQ_W-1:0]         sq_nxt [4];
  logic [SUM_W-1:0]        sum_r, sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 8; i++) sd_r[i] <= '0;
    end else if (en) begin
      sd_r[1] <= in_side;
      for (int i = 2; i <= 8; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // Stage 1: the sixteen products of goal and phase components.
  always_comb begin : s1_mul
    logic signed [2*CW-1:0] p;
    p = '0;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        p = $signed(g_in[a]) * $signed(q_in[b]);
        mq_nxt[a][b] = p[2*CW-1:FB];
      end
    end
  end

  // Stage 2: error vector, saturated, negated when the error scalar is negative.
  always_comb begin : s2_err
    logic signed [E_W-1:0] ew, ex, ey, ez;
    ew = E_W'(mq_r[0][0]) + E_W'(mq_r[1][1]) + E_W'(mq_r[2][2]) + E_W'(mq_r[3][3]);
    ex = -E_W'(mq_r[0][1]) + E_W'(mq_r[1][0]) - E_W'(mq_r[2][3]) + E_W'(mq_r[3][2]);
    ey = -E_W'(mq_r[0][2]) + E_W'(mq_r[1][3]) + E_W'(mq_r[2][0]) - E_W'(mq_r[3][1]);
    ez = -E_W'(mq_r[0][3]) - E_W'(mq_r[1][2]) + E_W'(mq_r[2][1]) + E_W'(mq_r[3][0]);
    ev_nxt[1] = ES_W'(sat_e(ex));
    ev_nxt[2] = ES_W'(sat_e(ey));
    ev_nxt[3] = ES_W'(sat_e(ez));
    if (ew[E_W-1]) begin
      for (int i = 1; i <= 3; i++) ev_nxt[i] = -ev_nxt[i];
    end
  end

  // Stage 3: products of the error vector and the phase.
  always_comb begin : s3_mul
    logic signed [ES_W+CW-1:0] p;
    p = '0;
    for (int a = 1; a <= 3; a++) begin
      for (int b = 0; b < 4; b++) begin
        p = ev_r[a] * $signed(qp_r[2][b]);
        dp_nxt[a][b] = p[ES_W+CW-1:FB];
      end
    end
  end

  // Stage 4: derivative (0, e) * q, saturated.
  always_comb begin : s4_der
    logic signed [DS_W-1:0] d0, d1, d2, d3;
    d0 = -DS_W'(dp_r[1][1]) - DS_W'(dp_r[2][2]) - DS_W'(dp_r[3][3]);
    d1 = DS_W'(dp_r[1][0]) + DS_W'(dp_r[2][3]) - DS_W'(dp_r[3][2]);
    d2 = -DS_W'(dp_r[1][3]) + DS_W'(dp_r[2][0]) + DS_W'(dp_r[3][1]);
    d3 = DS_W'(dp_r[1][2]) - DS_W'(dp_r[2][1]) + DS_W'(dp_r[3][0]);
    dv_nxt[0] = sat_d(d0);
    dv_nxt[1] = sat_d(d1);
    dv_nxt[2] = sat_d(d2);
    dv_nxt[3] = sat_d(d3);
  end

  // Stage 5: scale by the rate factor.
  always_comb begin
    for (int i = 0; i < 4; i++) pr_nxt[i] = dv_r[i] * $signed({1'b0, k});
  end

  // Stage 6: updated quaternion, split into magnitude and sign.
  always_comb begin : s6_upd
    logic signed [NQ_W-1:0] nq;
    nq = '0;
    for (int i = 0; i < 4; i++) begin
      nq = NQ_W'($signed(qp_r[5][i])) + NQ_W'($signed(pr_r[i][PR_W-1:INCSH]));
      neg6_nxt[i] = nq[NQ_W-1];
      mag6_nxt[i] = nq[NQ_W-1] ? MAG_W'(-nq) : MAG_W'(nq);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) sq_nxt[i] = SQ_W'(mag6_r[i]) * SQ_W'(mag6_r[i]);
    sum_nxt = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qp_r[1] <= q_in;
      for (int i = 2; i <= 5; i++) qp_r[i] <= qp_r[i-1];
      mq_r   <= mq_nxt;
      ev_r   <= ev_nxt;
      dp_r   <= dp_nxt;
      dv_r   <= dv_nxt;
      pr_r   <= pr_nxt;
      mag6_r <= mag6_nxt;
      neg6_r <= neg6_nxt;
      mag7_r <= mag6_r;
      neg7_r <= neg6_r;
      sq_r   <= sq_nxt;
      mag8_r <= mag7_r;
      neg8_r <= neg7_r;
      sum_r  <= sum_nxt;
    end
  end

  assign out_side = sd_r[8];
  assign mag      = mag8_r;
  assign neg      = neg8_r;
  assign sum      = sum_r;

endmodule

FILE: rtl/qts_sqrt.sv
// Pipelined integer square root of the sum of squares, one result bit per stage.
// Depends on qts_pkg.
module qts_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  qts_pkg::side_t             in_side,
  input  qts_pkg::mag4_t             mag_in,
  input  logic [3:0]                 neg_in,
  input  logic [qts_pkg::SUM_W-1:0]  sum_in,
  output qts_pkg::side_t             out_side,
  output qts_pkg::mag4_t             mag,
  output logic [3:0]                 neg,
  output logic [qts_pkg::RT_W-1:0]   norm,
  output logic                       zero
);
  import qts_pkg::*;

  logic [SUM_W-1:0] n_r [RT_W];
  logic [SUM_W-1:0] n_nxt [RT_W];
  logic [SUM_W-1:0] r_r [RT_W];
  logic [SUM_W-1:0] r_nxt [RT_W];
  side_t            sd_r [RT_W];
  mag4_t            mag_r [RT_W];
  logic [3:0]       neg_r [RT_W];
  logic             z_r [RT_W];

  for (genvar s = 0; s < RT_W; s++) begin : g_st
    logic [SUM_W-1:0] n_in, r_in;
    side_t            sd_in;
    mag4_t            m_in;
    logic [3:0]       ng_in;
    logic             z_in;

    if (s == 0) begin : g_first
      assign n_in  = sum_in;
      assign r_in  = '0;
      assign sd_in = in_side;
      assign m_in  = mag_in;
      assign ng_in = neg_in;
      assign z_in  = (sum_in == '0);
    end else begin : g_next
      assign n_in  = n_r[s-1];
      assign r_in  = r_r[s-1];
      assign sd_in = sd_r[s-1];
      assign m_in  = mag_r[s-1];
      assign ng_in = neg_r[s-1];
      assign z_in  = z_r[s-1];
    end

    // Digit-by-digit root: the trial bit walks down two places per stage.
    always_comb begin : step
      logic [SUM_W-1:0] bitv, t;
      bitv = SUM_W'(1) << (2 * (RT_W - 1 - s));
      t    = r_in + bitv;
      if (n_in >= t) begin
        n_nxt[s] = n_in - t;
        r_nxt[s] = (r_in >> 1) + bitv;
      end else begin
        n_nxt[s] = n_in;
        r_nxt[s] = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[s] <= '0;
      end else if (en) begin
        sd_r[s] <= sd_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s]   <= n_nxt[s];
        r_r[s]   <= r_nxt[s];
        mag_r[s] <= m_in;
        neg_r[s] <= ng_in;
        z_r[s]   <= z_in;
      end
    end
  end

  assign out_side = sd_r[RT_W-1];
  assign mag      = mag_r[RT_W-1];
  assign neg      = neg_r[RT_W-1];
  assign norm     = r_r[RT_W-1][RT_W-1:0];
  assign zero     = z_r[RT_W-1];

endmodule

FILE: rtl/qts_norm.sv
// Normalization: rounded quotients magnitude * 2^FB / norm for the four lanes,
// one quotient bit per stage after a setup stage. Depends on qts_pkg.
module qts_norm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  qts_pkg::side_t            in_side,
  input  qts_pkg::mag4_t            mag_in,
  input  logic [3:0]                neg_in,
  input  logic [qts_pkg::RT_W-1:0]  norm_in,
  input  logic                      zero_in,
  output qts_pkg::side_t            out_side,
  output qts_pkg::quo4_t            quo,
  output logic [3:0]                neg,
  output logic                      zero
);
  import qts_pkg::*;

  side_t            psd_r;
  logic [NUM_W-1:0] num_r [4];
  logic [NUM_W-1:0] num_nxt [4];
  logic [RT_W-1:0]  pdvs_r;
  logic [3:0]       pneg_r;
  logic             pz_r;

  logic [NUM_W-1:0] rem_r [QB][4];
  logic [NUM_W-1:0] rem_nxt [QB][4];
  quo4_t            quo_r [QB];
  quo4_t            quo_nxt [QB];
  logic [RT_W-1:0]  dvs_r [QB];
  side_t            sd_r [QB];
  logic [3:0]       neg_r [QB];
  logic             z_r [QB];

  // Rounding half up is folded into the dividend.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num_nxt[i] = NUM_W'({mag_in[i], {FB{1'b0}}}) + NUM_W'(norm_in >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psd_r <= '0;
    end else if (en) begin
      psd_r <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_nxt;
      pdvs_r <= norm_in;
      pneg_r <= neg_in;
      pz_r   <= zero_in;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [NUM_W-1:0] rm_in [4];
    quo4_t            qo_in;
    logic [RT_W-1:0]  dv_in;
    side_t            sd_in;
    logic [3:0]       ng_in;
    logic             z_in;

    if (s == 0) begin : g_first
      assign rm_in = num_r;
      assign qo_in = '0;
      assign dv_in = pdvs_r;
      assign sd_in = psd_r;
      assign ng_in = pneg_r;
      assign z_in  = pz_r;
    end else begin : g_next
      assign rm_in = rem_r[s-1];
      assign qo_in = quo_r[s-1];
      assign dv_in = dvs_r[s-1];
      assign sd_in = sd_r[s-1];
      assign ng_in = neg_r[s-1];
      assign z_in  = z_r[s-1];
    end

    // Restoring division, most significant quotient bit first.
    always_comb begin : step
      logic [NUM_W-1:0] sh;
      sh = NUM_W'(dv_in) << (QB - 1 - s);
      quo_nxt[s] = qo_in;
      for (int i = 0; i < 4; i++) begin
        if (rm_in[i] >= sh) begin
          rem_nxt[s][i] = rm_in[i] - sh;
          quo_nxt[s][i][QB-1-s] = 1'b1;
        end else begin
          rem_nxt[s][i] = rm_in[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[s] <= '0;
      end else if (en) begin
        sd_r[s] <= sd_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        dvs_r[s] <= dv_in;
        neg_r[s] <= ng_in;
        z_r[s]   <= z_in;
      end
    end
  end

  assign out_side = sd_r[QB-1];
  assign quo      = quo_r[QB-1];
  assign neg      = neg_r[QB-1];
  assign zero     = z_r[QB-1];

endmodule

FILE: rtl/quaternion_torque_step.sv
// Quaternion torque step: words pass the front, square root, divider and output register.
// Throughput one word per cycle; the 8-stage front, 29-stage square root and
// 16-stage divider advance together and stop only while a held result is stalled.
// Reset is synchronous, active low: valid bits clear, step_size returns to 656, gain to 256.
// Depends on qts_pkg, qts_front, qts_sqrt and qts_norm.
module quaternion_torque_step (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [qts_pkg::CW-1:0]      in_phase_w,
  input  logic signed [qts_pkg::CW-1:0]      in_phase_x,
  input  logic signed [qts_pkg::CW-1:0]      in_phase_y,
  input  logic signed [qts_pkg::CW-1:0]      in_phase_z,
  input  logic signed [qts_pkg::CW-1:0]      in_goal_w,
  input  logic signed [qts_pkg::CW-1:0]      in_goal_x,
  input  logic signed [qts_pkg::CW-1:0]      in_goal_y,
  input  logic signed [qts_pkg::CW-1:0]      in_goal_z,
  input  logic                               in_last_node,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [qts_pkg::CW-1:0]      out_new_w,
  output logic signed [qts_pkg::CW-1:0]      out_new_x,
  output logic signed [qts_pkg::CW-1:0]      out_new_y,
  output logic signed [qts_pkg::CW-1:0]      out_new_z,
  output logic                               out_last_result,
  input  logic                               cfg_we,
  input  logic [qts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qts_pkg::REG_W-1:0]          cfg_wdata
);
  import qts_pkg::*;

  logic [REG_W-1:0]   step_r, gain_r;
  logic [2*REG_W-1:0] kp;
  logic [K_W-1:0]     k_r;
  logic               en;
  side_t              in_side, f_side, s_side, n_side;
  quat_t              q_in, g_in;
  mag4_t              f_mag, s_mag;
  logic [3:0]         f_neg, s_neg, n_neg;
  logic [SUM_W-1:0]   f_sum;
  logic [RT_W-1:0]    s_norm;
  logic               s_zero, n_zero;
  quo4_t              n_quo;
  quat_t              res_nxt, res_r;
  logic               out_valid_r, last_r;

  // The whole pipeline moves unless a held result is being stalled.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RST;
      gain_r <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP: step_r <= cfg_wdata;
        REG_GAIN: gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign kp = (2*REG_W)'(gain_r) * (2*REG_W)'(step_r);

  always_ff @(posedge clk) begin
    k_r <= kp[2*REG_W-1:KSH];
  end

  assign in_side = '{valid: in_valid, last: in_last_node};
  assign q_in    = {in_phase_z, in_phase_y, in_phase_x, in_phase_w};
  assign g_in    = {in_goal_z, in_goal_y, in_goal_x, in_goal_w};

  qts_front u_front (
    .clk, .rst_n, .en,
    .in_side  (in_side),
    .q_in     (q_in),
    .g_in     (g_in),
    .k        (k_r),
    .out_side (f_side),
    .mag      (f_mag),
    .neg      (f_neg),
    .sum      (f_sum)
  );

  qts_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_side  (f_side),
    .mag_in   (f_mag),
    .neg_in   (f_neg),
    .sum_in   (f_sum),
    .out_side (s_side),
    .mag      (s_mag),
    .neg      (s_neg),
    .norm     (s_norm),
    .zero     (s_zero)
  );

  qts_norm u_norm (
    .clk, .rst_n, .en,
    .in_side  (s_side),
    .mag_in   (s_mag),
    .neg_in   (s_neg),
    .norm_in  (s_norm),
    .zero_in  (s_zero),
    .out_side (n_side),
    .quo      (n_quo),
    .neg      (n_neg),
    .zero     (n_zero)
  );

  // Apply the sign and saturate; a zero-length quaternion gives all zeros.
  always_comb begin : out_fmt
    logic signed [QB+1:0] sv;
    sv = '0;
    for (int i = 0; i < 4; i++) begin
      sv = $signed({2'b00, n_quo[i]});
      if (n_neg[i]) sv = -sv;
      res_nxt[i] = n_zero ? '0 : sat_o(sv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= n_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      last_r <= n_side.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_w       = res_r[0];
  assign out_new_x       = res_r[1];
  assign out_new_y       = res_r[2];
  assign out_new_z       = res_r[3];
  assign out_last_result = last_r;

endmodule

FILE: rtl/qts_checker.sv
// Port-level checker for the quaternion torque step block, bound to the top level.
// Depends on qts_pkg and quaternion_torque_step_defines.svh.
`include "quaternion_torque_step_defines.svh"

module qts_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [qts_pkg::CW-1:0]  out_new_w,
  input logic signed [qts_pkg::CW-1:0]  out_new_x,
  input logic signed [qts_pkg::CW-1:0]  out_new_y,
  input logic signed [qts_pkg::CW-1:0]  out_new_z,
  input logic                           out_last_result
);
  import qts_pkg::*;

  logic [4*CW:0] out_word;

  function automatic logic unit_ok(input logic signed [CW-1:0] v);
    return (v <= UNIT) && (v >= -UNIT);
  endfunction

  assign out_word = {out_new_w, out_new_x, out_new_y, out_new_z, out_last_result};

  // The input side stops exactly when a result word is held back.
  `QTS_ASSERT_IMPLY(a_stall_back, out_valid && out_stall, in_stall)
  `QTS_ASSERT_IMPLY(a_no_stall, !out_valid, !in_stall)
  // A stalled result word stays put.
  `QTS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_word))
  // A normalized component never exceeds one in magnitude.
  `QTS_ASSERT_IMPLY(a_unit, out_valid, unit_ok(out_new_w) && unit_ok(out_new_x) && unit_ok(out_new_y) && unit_ok(out_new_z))
  `QTS_ASSERT_RESET(a_reset, !rst_n, !out_valid)

endmodule

bind quaternion_torque_step qts_checker u_qts_checker (.*);
